>>> src/random_key_generator_core_defines.svh
// assertion macros for the random key generator core
`ifndef RANDOM_KEY_GENERATOR_CORE_DEFINES_SVH
`define RANDOM_KEY_GENERATOR_CORE_DEFINES_SVH

// implication checked on the same edge, off during reset
`define RKG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent checked on the next edge, off during reset
`define RKG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/rkg_pkg.sv
// shared constants and command types for the random key generator
`timescale 1ns / 1ps

package rkg_pkg;

  localparam int MAX_KEY_LENGTH = 16;
  localparam int CNT_W          = $clog2(MAX_KEY_LENGTH + 1);
  localparam int KEY_LEN_W      = 5;
  localparam int CFG_INDEX_W    = 2;

  localparam logic [63:0] LCG_MULTIPLIER = 64'd6364136223846793005;
  localparam logic [31:0] MOD36_MAGIC    = 32'd954437177;

  localparam logic KIND_RESEED = 1'b0;
  localparam logic KIND_KEY    = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_SEED_STATE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_SEQUENCE = 2'd1;

  localparam logic [1:0] MUL_LO_LO = 2'd0;
  localparam logic [1:0] MUL_LO_HI = 2'd1;
  localparam logic [1:0] MUL_HI_LO = 2'd2;
  localparam logic [1:0] MUL_DIV   = 2'd3;

  typedef struct packed {
    logic       seed_init;
    logic       seed_add;
    logic [1:0] mul_sel;
    logic       word_load;
    logic       acc_load;
    logic       acc_add;
    logic       state_upd;
    logic       emit;
    logic       last;
  } rkg_cmd_t;

  typedef struct packed {
    logic out_busy;
  } rkg_status_t;

endpackage

>>> src/rkg_ctrl.sv
// sequencer for reseed and key character generation
`timescale 1ns / 1ps

module rkg_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [rkg_pkg::KEY_LEN_W-1:0] in_key_length,
  input  rkg_pkg::rkg_status_t        status,
  output rkg_pkg::rkg_cmd_t           cmd
);
  import rkg_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SEED0 = 3'd1;
  localparam logic [2:0] ST_MUL0  = 3'd2;
  localparam logic [2:0] ST_MUL1  = 3'd3;
  localparam logic [2:0] ST_MUL2  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;
  localparam logic [2:0] ST_SEED1 = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic             mode_r, mode_nxt;
  logic             phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_kind;
          if (in_kind == KIND_RESEED) begin
            phase_nxt = 1'b0;
            state_nxt = ST_SEED0;
          end else begin
            if (int'(in_key_length) > MAX_KEY_LENGTH) begin
              cnt_nxt = CNT_W'(MAX_KEY_LENGTH);
            end else begin
              cnt_nxt = CNT_W'(in_key_length);
            end
            if (in_key_length != '0) begin
              state_nxt = ST_MUL0;
            end
          end
        end
      end
      ST_SEED0: begin
        cmd.seed_init = 1'b1;
        state_nxt     = ST_MUL0;
      end
      ST_MUL0: begin
        cmd.mul_sel   = MUL_LO_LO;
        cmd.word_load = 1'b1;
        state_nxt     = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_sel  = MUL_LO_HI;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_sel = MUL_HI_LO;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.mul_sel = MUL_DIV;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        // keep the mod 36 product stable while the beat waits
        cmd.mul_sel = MUL_DIV;
        if (mode_r == KIND_KEY) begin
          if (!status.out_busy) begin
            cmd.state_upd = 1'b1;
            cmd.emit      = 1'b1;
            cmd.last      = (cnt_r == CNT_W'(1));
            cnt_nxt       = cnt_r - CNT_W'(1);
            state_nxt     = (cnt_r == CNT_W'(1)) ? ST_IDLE : ST_MUL0;
          end
        end else begin
          cmd.state_upd = 1'b1;
          if (!phase_r) begin
            phase_nxt = 1'b1;
            state_nxt = ST_SEED1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SEED1: begin
        cmd.seed_add = 1'b1;
        state_nxt    = ST_MUL0;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= KIND_RESEED;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> src/rkg_datapath.sv
// pcg32 state, shared 32x32 multiplier, mod-36 mapping and output register
`timescale 1ns / 1ps

module rkg_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rkg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data,
  input  rkg_pkg::rkg_cmd_t               cmd,
  output rkg_pkg::rkg_status_t            status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [6:0]                      out_key_char,
  output logic [31:0]                     out_random_word,
  output logic                            out_last
);
  import rkg_pkg::*;

  logic [63:0] seed_state_r;
  logic [63:0] seed_seq_r;
  logic [63:0] state_r;
  logic [63:0] inc_r;
  logic [63:0] acc_r;
  logic [63:0] prod_r;
  logic [31:0] word_r;
  logic        out_valid_r;
  logic [6:0]  out_char_r;
  logic [31:0] out_word_r;
  logic        out_last_r;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mixed;
  logic [4:0]  rot;
  logic [31:0] word_nxt;
  logic [26:0] quot;
  logic [31:0] quot_x36;
  logic [5:0]  rem;
  logic [6:0]  char_nxt;

  assign cfg_ready = 1'b1;
  assign status.out_busy = out_valid_r & ~out_ready;

  // xsh rr output from the current state
  assign mixed    = 32'((state_r ^ (state_r >> 18)) >> 27);
  assign rot      = state_r[63:59];
  assign word_nxt = (mixed >> rot) | (mixed << (5'(~rot + 5'd1)));

  always_comb begin
    case (cmd.mul_sel)
      MUL_LO_LO: begin
        mul_a = state_r[31:0];
        mul_b = LCG_MULTIPLIER[31:0];
      end
      MUL_LO_HI: begin
        mul_a = state_r[31:0];
        mul_b = LCG_MULTIPLIER[63:32];
      end
      MUL_HI_LO: begin
        mul_a = state_r[63:32];
        mul_b = LCG_MULTIPLIER[31:0];
      end
      default: begin
        mul_a = {2'b00, word_r[31:2]};
        mul_b = MOD36_MAGIC;
      end
    endcase
  end

  // word / 36 = (word >> 2) / 9 by reciprocal
  assign quot     = prod_r[59:33];
  assign quot_x36 = {quot, 5'b0} + {3'b0, quot, 2'b0};
  assign rem      = 6'(word_r - quot_x36);
  assign char_nxt = (rem < 6'd10) ? (7'd48 + {1'b0, rem}) : (7'd55 + {1'b0, rem});

  always_ff @(posedge clk) begin
    prod_r <= {32'b0, mul_a} * {32'b0, mul_b};
    if (cmd.word_load) begin
      word_r <= word_nxt;
    end
    if (cmd.acc_load) begin
      acc_r <= prod_r;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + {prod_r[31:0], 32'b0};
    end
    if (cmd.emit) begin
      out_char_r <= char_nxt;
      out_word_r <= word_r;
      out_last_r <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_state_r <= '0;
      seed_seq_r   <= '0;
      state_r      <= '0;
      inc_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SEED_STATE:    seed_state_r <= cfg_data;
          REG_SEED_SEQUENCE: seed_seq_r   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.seed_init) begin
        state_r <= '0;
        inc_r   <= {seed_seq_r[62:0], 1'b1};
      end else if (cmd.seed_add) begin
        state_r <= state_r + seed_state_r;
      end else if (cmd.state_upd) begin
        state_r <= acc_r + (inc_r | 64'd1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_char    = out_char_r;
  assign out_random_word = out_word_r;
  assign out_last        = out_last_r;

endmodule

>>> src/random_key_generator_core.sv
// top level of the pcg32 xsh rr random key generator
//
//  channel | direction | beat contents
//  in      | input     | in_kind, in_key_length
//  out     | output    | out_key_char, out_random_word, out_last
//  cfg     | input     | cfg_index, cfg_data (always ready)
//
// for each key character, three 32x32 partial products of the lcg
// multiply and one reciprocal product for mod 36 share a single multiplier
// a reseed: seed init, update, seed add, update; a zero length key is dropped
// a new input beat is taken only when the previous item is finished
// a character waits in its last cycle while the output register is still full
// synchronous active low reset clears state, increment and config registers
`timescale 1ns / 1ps
`include "random_key_generator_core_defines.svh"

module random_key_generator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [rkg_pkg::KEY_LEN_W-1:0]   in_key_length,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [6:0]                      out_key_char,
  output logic [31:0]                     out_random_word,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rkg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);
  import rkg_pkg::*;

  rkg_cmd_t    cmd;
  rkg_status_t status;

  rkg_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_key_length (in_key_length),
    .status        (status),
    .cmd           (cmd)
  );

  rkg_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_key_char    (out_key_char),
    .out_random_word (out_random_word),
    .out_last        (out_last)
  );

  `RKG_ASSERT(a_emit_slot_free, cmd.emit |-> !(out_valid && !out_ready), "beat overwritten")
  `RKG_ASSERT(a_cmd_exclusive, $onehot0({cmd.seed_init, cmd.seed_add, cmd.state_upd, cmd.acc_load}), "command clash")
  `RKG_ASSERT_NEXT(a_last_idle, cmd.emit && cmd.last, in_ready, "not idle after last beat")
  `RKG_ASSERT_NEXT(a_zero_len_idle, in_valid && in_ready && (in_kind == KIND_KEY) && (in_key_length == '0), in_ready, "zero length key not dropped")

endmodule
